>>> design/mpq_pkg.sv
// shared types and constants of the multilevel priority task queue
// no dependencies

package mpq_pkg;

  localparam int DEF_NUM_LEVELS   = 16;
  localparam int DEF_TASK_SLOTS   = 64;
  localparam int DEF_TASK_ID_BITS = 16;

  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 2;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TAKE = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

endpackage

>>> design/mpq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mpq_prio_enc.sv
// lowest-index priority encoder over the level occupancy bitmap
// depends on mpq_pkg

module mpq_prio_enc import mpq_pkg::*; #(
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  input  logic [NUM_LEVELS-1:0]         occ_i,
  output logic                          found_o,
  output logic [$clog2(NUM_LEVELS)-1:0] idx_o
);

  localparam int LW = $clog2(NUM_LEVELS);

  always_comb begin
    idx_o = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (occ_i[i]) begin
        idx_o = LW'(i);
      end
    end
  end

  assign found_o = |occ_i;

endmodule

>>> design/multilevel_priority_task_queue_core.sv
// multilevel priority task queue: one linked fifo of task ids per level
// level heads, tails and occupancy in flops, slot links and tasks in rams
// depends on mpq_pkg, mpq_ram, mpq_prio_enc
//
// usage
//   request channel: start with req_type_i, priority_req_i, task_id_i; a
//   request is taken on every clock edge where start is high and busy is
//   low. busy stays low, so a request can be given in every cycle.
//   add files task_id_i at the tail of level priority_req_i (levels beyond
//   the top saturate); take removes the oldest task of the lowest occupied
//   level.
//   result channel: done_o is high for one cycle with status_o,
//   out_task_id_o, out_priority_o and now_empty_o; the receiver cannot
//   stall it.
//   a request is first registered in the request stage, and its result is
//   then registered in the result registers. throughput: one request per cycle, set by
//   the single read and write port of each slot ram; the head, tail and
//   ram read address for a request are looked up in its request cycle.
//   reset: the queue is empty and all slots sit on the free list; no
//   clearing pass is needed, so requests are taken right after reset.

module multilevel_priority_task_queue_core import mpq_pkg::*; #(
  parameter int NUM_LEVELS   = DEF_NUM_LEVELS,
  parameter int TASK_SLOTS   = DEF_TASK_SLOTS,
  parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type_i,
  input  logic [PRIO_W-1:0]       priority_req_i,
  input  logic [TASK_ID_BITS-1:0] task_id_i,
  output logic                    done_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [TASK_ID_BITS-1:0] out_task_id_o,
  output logic [PRIO_W-1:0]       out_priority_o,
  output logic                    now_empty_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int SW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);

  // queue state
  logic [NUM_LEVELS-1:0] occ_q, occ_d;
  logic [SW-1:0]         head_q [NUM_LEVELS];
  logic [SW-1:0]         head_d [NUM_LEVELS];
  logic [SW-1:0]         tail_q [NUM_LEVELS];
  logic [SW-1:0]         tail_d [NUM_LEVELS];
  logic [SW-1:0]         free_head_q, free_head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         fresh_q, fresh_d;

  // request stage
  logic                    vld_q;
  logic                    req_q;
  logic [TASK_ID_BITS-1:0] task_q;
  logic [LW-1:0]           lvl_q;
  logic                    found_q;
  logic [SW-1:0]           head_sel_q;
  logic [SW-1:0]           tail_sel_q;
  logic                    occ_sel_q;
  logic [SW-1:0]           link_raddr_q;
  logic                    link_hit_q;
  logic [SW-1:0]           link_byp_q;
  logic                    task_hit_q;
  logic [TASK_ID_BITS-1:0] task_byp_q;

  // result registers
  logic                    done_q;
  status_e                 status_q, status_d;
  logic [TASK_ID_BITS-1:0] out_task_q;
  logic [PRIO_W-1:0]       out_prio_q;
  logic                    now_empty_q;

  // lookup for the incoming request
  logic          accept;
  logic          enc_found;
  logic [LW-1:0] enc_idx;
  logic [LW-1:0] add_lvl;
  logic [LW-1:0] sel_lvl;
  logic [SW-1:0] head_a;
  logic [SW-1:0] link_raddr;

  // ram ports
  logic                    link_we;
  logic [SW-1:0]           link_waddr;
  logic [SW-1:0]           link_rdata;
  logic                    task_we;
  logic [TASK_ID_BITS-1:0] task_rdata;

  // request execution
  logic                    add_ok;
  logic                    add_full;
  logic                    take_ok;
  logic                    take_last;
  logic [SW-1:0]           link_eff;
  logic [SW-1:0]           link_next;
  logic [TASK_ID_BITS-1:0] task_eff;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // execution of the registered request
  assign add_full  = vld_q && (req_q == REQ_ADD) && (count_q == CW'(TASK_SLOTS));
  assign add_ok    = vld_q && (req_q == REQ_ADD) && (count_q != CW'(TASK_SLOTS));
  assign take_ok   = vld_q && (req_q == REQ_TAKE) && found_q;
  assign take_last = (head_sel_q == tail_sel_q);

  // slots never handed out link to the next slot; the ram holds no link for them
  assign link_next = (link_raddr_q == SW'(TASK_SLOTS - 1)) ? '0 : link_raddr_q + SW'(1);
  assign link_eff  = link_hit_q ? link_byp_q :
                     (CW'(link_raddr_q) >= fresh_q) ? link_next : link_rdata;
  assign task_eff  = task_hit_q ? task_byp_q : task_rdata;

  assign link_we    = (add_ok && occ_sel_q) || take_ok;
  assign link_waddr = add_ok ? tail_sel_q : head_sel_q;
  assign task_we    = add_ok;

  always_comb begin
    occ_d       = occ_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    if (add_ok) begin
      occ_d[lvl_q]  = 1'b1;
      tail_d[lvl_q] = free_head_q;
      if (!occ_sel_q) begin
        head_d[lvl_q] = free_head_q;
      end
      free_head_d = link_eff;
      count_d     = count_q + CW'(1);
      if (CW'(free_head_q) == fresh_q) begin
        fresh_d = fresh_q + CW'(1);
      end
    end else if (take_ok) begin
      if (take_last) begin
        occ_d[lvl_q] = 1'b0;
      end else begin
        head_d[lvl_q] = link_eff;
      end
      free_head_d = head_sel_q;
      count_d     = count_q - CW'(1);
    end
  end

  always_comb begin
    status_d = STAT_OK;
    if (add_full) begin
      status_d = STAT_FULL;
    end else if (vld_q && (req_q == REQ_TAKE) && !found_q) begin
      status_d = STAT_EMPTY;
    end
  end

  // lookup on the state as it stands after the registered request
  mpq_prio_enc #(
    .NUM_LEVELS(NUM_LEVELS)
  ) u_prio_enc (
    .occ_i  (occ_d),
    .found_o(enc_found),
    .idx_o  (enc_idx)
  );

  always_comb begin
    if (int'(priority_req_i) >= NUM_LEVELS) begin
      add_lvl = LW'(NUM_LEVELS - 1);
    end else begin
      add_lvl = LW'(priority_req_i);
    end
  end

  assign sel_lvl    = (req_type_i == REQ_TAKE) ? enc_idx : add_lvl;
  assign head_a     = head_d[enc_idx];
  assign link_raddr = (req_type_i == REQ_TAKE) ? head_a : free_head_d;

  mpq_ram #(
    .WIDTH(SW),
    .DEPTH(TASK_SLOTS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(free_head_q),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  mpq_ram #(
    .WIDTH(TASK_ID_BITS),
    .DEPTH(TASK_SLOTS)
  ) u_task_ram (
    .clk_i  (clk_i),
    .we_i   (task_we),
    .waddr_i(free_head_q),
    .wdata_i(task_q),
    .raddr_i(head_a),
    .rdata_o(task_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      fresh_q     <= '0;
      vld_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      vld_q       <= accept;
      done_q      <= vld_q;
    end
  end

  // level pointers, undefined until written
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  // request payload and ram bypass
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_type_i;
      task_q     <= task_id_i;
      lvl_q      <= sel_lvl;
      found_q    <= enc_found;
      head_sel_q <= head_a;
      tail_sel_q <= tail_d[sel_lvl];
      occ_sel_q  <= occ_d[sel_lvl];
    end
    link_raddr_q <= link_raddr;
    link_hit_q   <= link_we && (link_waddr == link_raddr);
    link_byp_q   <= free_head_q;
    task_hit_q   <= task_we && (free_head_q == head_a);
    task_byp_q   <= task_q;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      status_q    <= status_d;
      out_task_q  <= take_ok ? task_eff : '0;
      out_prio_q  <= take_ok ? PRIO_W'(lvl_q) : '0;
      now_empty_q <= (count_d == '0);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_task_id_o  = out_task_q;
  assign out_priority_o = out_prio_q;
  assign now_empty_o    = now_empty_q;

endmodule

>>> design/mpq_checker.sv
// port-level checks of the multilevel priority task queue, bound to the top
// depends on mpq_pkg and multilevel_priority_task_queue_core

module mpq_checker import mpq_pkg::*; #(
  parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    req_type_i,
  input logic                    done_o,
  input logic [STATUS_W-1:0]     status_o,
  input logic [TASK_ID_BITS-1:0] out_task_id_o,
  input logic [PRIO_W-1:0]       out_priority_o,
  input logic                    now_empty_o
);

  // each request yields exactly one result, and each result has a request
  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("request without result");

  a_done_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without request");

  // a take on an empty queue returns nothing and leaves it empty
  a_empty_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_EMPTY)) |->
      (now_empty_o && (out_task_id_o == '0) && (out_priority_o == '0)))
    else $error("empty take result inconsistent");

  // a full store and a successful add both leave tasks behind
  a_add_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == STAT_FULL) ||
                ((status_o == STAT_OK) && ($past(req_type_i, 2) == REQ_ADD)))) |->
      (!now_empty_o && (out_task_id_o == '0)))
    else $error("add result inconsistent");

  // status is always one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == STAT_OK) || (status_o == STAT_EMPTY) ||
                (status_o == STAT_FULL)))
    else $error("undefined status code");

endmodule

bind multilevel_priority_task_queue_core mpq_checker #(
  .TASK_ID_BITS(TASK_ID_BITS)
) u_mpq_checker (.*);
